FILE: rtl/core/hwmc_pkg.sv
// Shared types and constants for the Hamming-distance-one window match counter.
package hwmc_pkg;

	localparam logic [1:0] OP_CLEAR   = 2'd0;
	localparam logic [1:0] OP_PATTERN = 2'd1;
	localparam logic [1:0] OP_REF     = 2'd2;
	localparam logic [1:0] OP_END     = 2'd3;

	localparam int          COUNT_W   = 24;
	localparam logic [23:0] COUNT_MAX = 24'hFF_FFFF;

	localparam logic [7:0] CHAR_A       = 8'h41;
	localparam logic [7:0] CHAR_C       = 8'h43;
	localparam logic [7:0] CHAR_G       = 8'h47;
	localparam logic [7:0] CHAR_T       = 8'h54;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
	localparam logic [7:0] CASE_OFFSET  = 8'h20;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] symbol;
	} req_t;

	typedef struct packed {
		logic [COUNT_W-1:0] match_count;
		logic               count_saturated;
	} rsp_t;

	typedef struct packed {
		logic       valid;
		logic [1:0] operation;
		logic       hit;
	} ctl_t;

endpackage

FILE: rtl/core/hwmc_window.sv
// Pattern and reference shift registers with the parallel window compare.
module hwmc_window #(
	parameter int PATTERN_MAX = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          valid_s1,
	input  hwmc_pkg::req_t req_s1,
	output hwmc_pkg::ctl_t ctl_s2
);

	localparam int LW = $clog2(PATTERN_MAX + 1);

	logic [7:0]             pat_q [PATTERN_MAX];
	logic [7:0]             win_q [PATTERN_MAX];
	logic [PATTERN_MAX-1:0] base_q;
	logic [LW-1:0]          len_q;
	logic [LW-1:0]          fill_q;

	logic [7:0]             sym_up;
	logic                   sym_base;
	logic [7:0]             win_new [PATTERN_MAX];
	logic [PATTERN_MAX-1:0] base_new;
	logic [PATTERN_MAX-1:0] mm;
	logic [PATTERN_MAX-1:0] bm;
	logic [LW-1:0]          fill_nxt;
	logic                   multi;
	logic                   hit;
	logic                   is_pat;
	logic                   is_ref;

	assign is_pat = valid_s1 && (req_s1.operation == hwmc_pkg::OP_PATTERN)
		&& (len_q < LW'(PATTERN_MAX));
	assign is_ref = valid_s1 && (req_s1.operation == hwmc_pkg::OP_REF);

	always_comb begin
		if ((req_s1.symbol >= hwmc_pkg::CHAR_LOWER_A) &&
				(req_s1.symbol <= hwmc_pkg::CHAR_LOWER_Z)) begin
			sym_up = req_s1.symbol - hwmc_pkg::CASE_OFFSET;
		end else begin
			sym_up = req_s1.symbol;
		end
		sym_base = (sym_up == hwmc_pkg::CHAR_A) || (sym_up == hwmc_pkg::CHAR_C) ||
			(sym_up == hwmc_pkg::CHAR_G) || (sym_up == hwmc_pkg::CHAR_T);
	end

	always_comb begin
		win_new[0]  = sym_up;
		base_new[0] = sym_base;
		for (int k = 1; k < PATTERN_MAX; k++) begin
			win_new[k]  = win_q[k-1];
			base_new[k] = base_q[k-1];
		end
		for (int k = 0; k < PATTERN_MAX; k++) begin
			mm[k] = (LW'(k) < len_q) && (win_new[k] != pat_q[k]);
			bm[k] = mm[k] && base_new[k];
		end
	end

	assign fill_nxt = (fill_q < LW'(PATTERN_MAX)) ? fill_q + LW'(1) : fill_q;
	assign multi    = |(mm & (mm - PATTERN_MAX'(1)));
	assign hit      = (len_q != '0) && (fill_nxt >= len_q) && !multi
		&& ((mm == '0) || (|bm));

	// advance the shift registers; entries past the fill level are never counted
	always_ff @(posedge clk) begin
		if (is_pat) begin
			pat_q[0] <= req_s1.symbol;
			for (int k = 1; k < PATTERN_MAX; k++) begin
				pat_q[k] <= pat_q[k-1];
			end
		end
		if (is_ref) begin
			for (int k = 0; k < PATTERN_MAX; k++) begin
				win_q[k] <= win_new[k];
			end
			base_q <= base_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			fill_q <= '0;
			ctl_s2 <= '0;
		end else begin
			ctl_s2.valid     <= valid_s1;
			ctl_s2.operation <= req_s1.operation;
			ctl_s2.hit       <= hit;
			if (valid_s1) begin
				case (req_s1.operation)
					hwmc_pkg::OP_CLEAR: begin
						len_q  <= '0;
						fill_q <= '0;
					end
					hwmc_pkg::OP_PATTERN: begin
						if (is_pat) begin
							len_q <= len_q + LW'(1);
						end
					end
					hwmc_pkg::OP_REF: begin
						fill_q <= fill_nxt;
					end
					hwmc_pkg::OP_END: begin
						fill_q <= '0;
					end
					default: begin
						fill_q <= fill_q;
					end
				endcase
			end
		end
	end

endmodule

FILE: rtl/core/hwmc_counter.sv
// Saturating window counter and result register.
module hwmc_counter (
	input  logic           clk,
	input  logic           arst_n,
	input  hwmc_pkg::ctl_t ctl_s2,
	output hwmc_pkg::rsp_t result,
	output logic           done
);

	logic [hwmc_pkg::COUNT_W-1:0] count_q;
	logic                         sat_q;
	hwmc_pkg::rsp_t               result_q;
	logic                         done_q;

	always_ff @(posedge clk) begin
		if (ctl_s2.valid && (ctl_s2.operation == hwmc_pkg::OP_END)) begin
			result_q.match_count     <= count_q;
			result_q.count_saturated <= sat_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sat_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= ctl_s2.valid && (ctl_s2.operation == hwmc_pkg::OP_END);
			if (ctl_s2.valid) begin
				case (ctl_s2.operation)
					hwmc_pkg::OP_CLEAR, hwmc_pkg::OP_END: begin
						count_q <= '0;
						sat_q   <= 1'b0;
					end
					hwmc_pkg::OP_REF: begin
						if (ctl_s2.hit && (count_q != hwmc_pkg::COUNT_MAX)) begin
							count_q <= count_q + hwmc_pkg::COUNT_W'(1);
							if (count_q == hwmc_pkg::COUNT_MAX - hwmc_pkg::COUNT_W'(1)) begin
								sat_q <= 1'b1;
							end
						end
					end
					default: begin
						count_q <= count_q;
					end
				endcase
			end
		end
	end

	assign result = result_q;
	assign done   = done_q;

endmodule

FILE: rtl/core/hamming1_window_match_counter_top.sv
// Top level of the Hamming-distance-one window match counter.
// The block takes one request per clock cycle and never raises busy. Pattern
// bytes shift into a pattern register and reference bytes into a window register;
// every window position is compared in parallel on the registered request and the
// count updates from the registered outcome. An end request passes the request,
// control and result registers, its result shown on result for one cycle with done
// high; the receiver cannot stall it, so it must take every result as it comes.
module hamming1_window_match_counter_top #(
	parameter int PATTERN_MAX = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  hwmc_pkg::req_t request,
	output hwmc_pkg::rsp_t result,
	output logic           done
);

	logic           valid_s1;
	hwmc_pkg::req_t req_s1;
	hwmc_pkg::ctl_t ctl_s2;

	assign busy = 1'b0;

	always_ff @(posedge clk) begin
		req_s1 <= request;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	hwmc_window #(
		.PATTERN_MAX(PATTERN_MAX)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_s1(valid_s1),
		.req_s1  (req_s1),
		.ctl_s2  (ctl_s2)
	);

	hwmc_counter u_counter (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl_s2(ctl_s2),
		.result(result),
		.done  (done)
	);

endmodule

FILE: dv/tb.sv
// Self-checking bench for the Hamming-distance-one window match counter.
`timescale 1ns / 1ps

module tb;

	localparam int PAT_MAX      = 32;
	localparam int ITEM_GOAL    = 1450;
	localparam int CALM_AFTER   = 1250;
	localparam int STALL_LIMIT  = 1000;
	localparam int DRAIN_CYCLES = 8;

	class window_count_board;
		logic [7:0]                   pattern_bytes[PAT_MAX];
		int unsigned                  pattern_len;
		logic [7:0]                   window[PAT_MAX];
		int unsigned                  fill;
		logic [hwmc_pkg::COUNT_W-1:0] count;
		logic                         saturated;
		hwmc_pkg::rsp_t               counts_due[$];
		int unsigned                  bad;
		int unsigned                  checked;
		int unsigned                  longest;
		int unsigned                  top_count;

		function new();
			pattern_len = 0;
			fill        = 0;
			count       = '0;
			saturated   = 1'b0;
			bad         = 0;
			checked     = 0;
			longest     = 0;
			top_count   = 0;
		endfunction

		function bit window_hit();
			int unsigned misses;
			logic [7:0]  diff;
			logic [7:0]  w;
			misses = 0;
			diff   = '0;
			if (pattern_len == 0 || fill < pattern_len) return 1'b0;
			for (int j = 0; j < pattern_len; j++) begin
				w = window[pattern_len - 1 - j];
				if (w != pattern_bytes[j]) begin
					misses++;
					diff = w;
					if (misses > 1) return 1'b0;
				end
			end
			return misses == 0 || diff == hwmc_pkg::CHAR_A || diff == hwmc_pkg::CHAR_C ||
				diff == hwmc_pkg::CHAR_G || diff == hwmc_pkg::CHAR_T;
		endfunction

		function void note_request(hwmc_pkg::req_t r);
			logic [7:0]     up;
			hwmc_pkg::rsp_t due;
			case (r.operation)
			hwmc_pkg::OP_CLEAR: begin
				pattern_len = 0;
				fill        = 0;
				count       = '0;
				saturated   = 1'b0;
			end
			hwmc_pkg::OP_PATTERN: begin
				if (pattern_len < PAT_MAX) begin
					pattern_bytes[pattern_len] = r.symbol;
					pattern_len++;
					if (pattern_len > longest) longest = pattern_len;
				end
			end
			hwmc_pkg::OP_REF: begin
				up = r.symbol;
				if (up >= hwmc_pkg::CHAR_LOWER_A && up <= hwmc_pkg::CHAR_LOWER_Z)
					up = up - hwmc_pkg::CASE_OFFSET;
				for (int k = PAT_MAX - 1; k > 0; k--) window[k] = window[k - 1];
				window[0] = up;
				if (fill < PAT_MAX) fill++;
				if (window_hit() && count != hwmc_pkg::COUNT_MAX) begin
					count++;
					if (count == hwmc_pkg::COUNT_MAX) saturated = 1'b1;
				end
			end
			hwmc_pkg::OP_END: begin
				due.match_count     = count;
				due.count_saturated = saturated;
				counts_due = {counts_due, due};
				if (count > top_count) top_count = count;
				fill      = 0;
				count     = '0;
				saturated = 1'b0;
			end
			endcase
		endfunction

		function void check_count(hwmc_pkg::rsp_t got);
			hwmc_pkg::rsp_t want;
			if (counts_due.size() == 0) begin
				bad++;
				if (bad <= 10)
					$display("unexpected count result: count %0d saturated %0b",
						got.match_count, got.count_saturated);
				return;
			end
			want = counts_due.pop_front();
			checked++;
			if (got.match_count !== want.match_count ||
				got.count_saturated !== want.count_saturated) begin
				bad++;
				if (bad <= 10)
					$display("count mismatch: expected %0d/%0b, got %0d/%0b",
						want.match_count, want.count_saturated,
						got.match_count, got.count_saturated);
			end
		endfunction
	endclass

	logic           clk     = 1'b0;
	logic           arst_n  = 1'b0;
	logic           start   = 1'b0;
	hwmc_pkg::req_t request = '0;
	hwmc_pkg::rsp_t result;
	logic           busy;
	logic           done;

	window_count_board board;
	int unsigned       sent;
	int unsigned       stall_cycles;
	int unsigned       gap_odds;
	bit                calm;
	logic [7:0]        cur_pattern[$];

	always #6 clk = ~clk;

	hamming1_window_match_counter_top #(
		.PATTERN_MAX(PAT_MAX)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.result  (result),
		.done    (done)
	);

	always @(posedge clk) begin
		if (arst_n && done) board.check_count(result);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) stall_cycles = 0;
			else stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("tb: errors");
				$finish;
			end
		end
	end

	function automatic logic [7:0] random_base();
		case ($urandom_range(0, 3))
		0: return hwmc_pkg::CHAR_A;
		1: return hwmc_pkg::CHAR_C;
		2: return hwmc_pkg::CHAR_G;
		default: return hwmc_pkg::CHAR_T;
		endcase
	endfunction

	function automatic logic [7:0] random_ref_byte();
		logic [7:0] b;
		b = random_base();
		case ($urandom_range(0, 7))
		0: b = 8'($urandom_range(0, 255));
		1, 2: b = b | hwmc_pkg::CASE_OFFSET;
		default: ;
		endcase
		return b;
	endfunction

	task automatic idle_for(int unsigned n);
		repeat (n) begin
			@(negedge clk);
			start   <= 1'b0;
			request <= hwmc_pkg::req_t'(10'($urandom));
		end
	endtask

	task automatic send_request(logic [1:0] op, logic [7:0] sym);
		hwmc_pkg::req_t r;
		r.operation = op;
		r.symbol    = sym;
		if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
			idle_for($urandom_range(1, 18));
		@(negedge clk);
		start   <= 1'b1;
		request <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		board.note_request(r);
		sent++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (board.counts_due.size() != 0) @(posedge clk);
	endtask

	task automatic run_sequence();
		logic [7:0]  refs[$];
		logic [7:0]  b;
		int unsigned plen;
		int unsigned rlen;
		int unsigned pick;
		int unsigned pos;
		case ($urandom_range(0, 3))
		0: gap_odds = 0;
		1: gap_odds = 3;
		default: gap_odds = 12;
		endcase
		if (cur_pattern.size() == 0 || $urandom_range(0, 9) != 0) begin
			send_request(hwmc_pkg::OP_CLEAR, 8'($urandom_range(0, 255)));
			cur_pattern.delete();
			pick = $urandom_range(0, 11);
			if (pick == 0) plen = 0;
			else if (pick == 1) plen = PAT_MAX + $urandom_range(0, 3);
			else plen = $urandom_range(1, 8);
			repeat (plen) begin
				b = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : random_base();
				send_request(hwmc_pkg::OP_PATTERN, b);
				if (cur_pattern.size() < PAT_MAX) cur_pattern = {cur_pattern, b};
			end
		end
		rlen = $urandom_range(0, cur_pattern.size() + 12);
		while (refs.size() < rlen) begin
			if (cur_pattern.size() != 0 && $urandom_range(0, 2) == 0) begin
				pos = $urandom_range(0, cur_pattern.size() * 2);
				for (int j = 0; j < cur_pattern.size(); j++) begin
					b = cur_pattern[j];
					if (j == pos) b = random_ref_byte();
					else if (b >= hwmc_pkg::CHAR_A &&
						b <= (hwmc_pkg::CHAR_LOWER_Z - hwmc_pkg::CASE_OFFSET) &&
						$urandom_range(0, 3) == 0) b = b | hwmc_pkg::CASE_OFFSET;
					refs = {refs, b};
				end
			end else begin
				refs = {refs, random_ref_byte()};
			end
		end
		foreach (refs[k]) begin
			if ($urandom_range(0, 39) == 0) begin
				b = random_base();
				send_request(hwmc_pkg::OP_PATTERN, b);
				if (cur_pattern.size() < PAT_MAX) cur_pattern = {cur_pattern, b};
			end
			if ($urandom_range(0, 49) == 0)
				send_request(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
			send_request(hwmc_pkg::OP_REF, refs[k]);
		end
		send_request(hwmc_pkg::OP_END, 8'($urandom_range(0, 255)));
		if ($urandom_range(0, 14) == 0) wait_drained();
	endtask

	initial begin
		logic [7:0] corner_refs[$];
		board        = new();
		calm         = 1'b0;
		gap_odds     = 0;
		sent         = 0;
		stall_cycles = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// count at reset, then reference bytes against an empty pattern
		send_request(hwmc_pkg::OP_END, 8'hFF);
		send_request(hwmc_pkg::OP_REF, 8'h00);
		send_request(hwmc_pkg::OP_END, 8'h00);
		send_request(hwmc_pkg::OP_CLEAR, 8'hFF);
		send_request(hwmc_pkg::OP_PATTERN, hwmc_pkg::CHAR_A);
		send_request(hwmc_pkg::OP_PATTERN, hwmc_pkg::CHAR_C);
		send_request(hwmc_pkg::OP_PATTERN, hwmc_pkg::CHAR_G);
		// reference shorter than the pattern
		send_request(hwmc_pkg::OP_REF, hwmc_pkg::CHAR_A | hwmc_pkg::CASE_OFFSET);
		send_request(hwmc_pkg::OP_REF, hwmc_pkg::CHAR_C | hwmc_pkg::CASE_OFFSET);
		send_request(hwmc_pkg::OP_END, 8'h55);
		// exact hit, non-base mismatch, base mismatch
		corner_refs = '{hwmc_pkg::CHAR_A | hwmc_pkg::CASE_OFFSET,
			hwmc_pkg::CHAR_C | hwmc_pkg::CASE_OFFSET,
			hwmc_pkg::CHAR_G | hwmc_pkg::CASE_OFFSET,
			hwmc_pkg::CHAR_A | hwmc_pkg::CASE_OFFSET, hwmc_pkg::CHAR_C, 8'h4E,
			hwmc_pkg::CHAR_A | hwmc_pkg::CASE_OFFSET,
			hwmc_pkg::CHAR_C | hwmc_pkg::CASE_OFFSET,
			hwmc_pkg::CHAR_T | hwmc_pkg::CASE_OFFSET};
		foreach (corner_refs[k]) send_request(hwmc_pkg::OP_REF, corner_refs[k]);
		send_request(hwmc_pkg::OP_END, 8'hAA);
		// grow the pattern mid-stream
		send_request(hwmc_pkg::OP_REF, hwmc_pkg::CHAR_A);
		send_request(hwmc_pkg::OP_PATTERN, hwmc_pkg::CHAR_T);
		send_request(hwmc_pkg::OP_REF, 8'hFF);
		send_request(hwmc_pkg::OP_PATTERN, 8'h00);
		send_request(hwmc_pkg::OP_END, 8'h0F);
		wait_drained();

		while (sent < ITEM_GOAL) begin
			if (sent >= CALM_AFTER) calm = 1'b1;
			run_sequence();
		end
		@(negedge clk);
		start <= 1'b0;
		while (board.counts_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("summary: %0d requests sent, %0d counts checked, %0d mismatches",
			sent, board.checked, board.bad);
		$display("summary: patterns up to %0d bytes, highest count %0d",
			board.longest, board.top_count);
		if (board.bad == 0 && board.counts_due.size() == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule
